>>> hdl/cvlc_pkg.sv
// Package for the circle viewport line clipper: widths, codes and control structs
// shared by the controller and the datapath, and the datapath's constant helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cvlc_pkg;

  localparam int unsigned CIRCLE_RADIUS = 99;
  localparam int unsigned SEARCH_COUNT  = 10;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned SCALE_W   = 13;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PROD_W    = COORD_W + SCALE_W;
  localparam int unsigned SC_W      = PROD_W - FRAC_W;            // scaled magnitude
  localparam int unsigned RAD_W     = $clog2(CIRCLE_RADIUS + 1);
  localparam int unsigned HW_DEPTH  = 2 ** RAD_W;
  localparam int unsigned STEP_W    = $clog2(SEARCH_COUNT + 2);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(495);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    PT_OUTSIDE,
    PT_INSIDE,
    PT_BOUNDARY
  } pt_class_e;

  typedef enum logic [1:0] {
    MS_P0,
    MS_P1,
    MS_GUESS
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_CHK1,
    ST_DECIDE,
    ST_MULG,
    ST_CLSG
  } ctrl_state_e;

  typedef struct packed {
    logic     load;         // capture the request endpoints
    mul_sel_e mul_sel;      // point fed to the scaler
    logic     mul_en;       // register the scaled magnitudes
    logic     save_in0;     // latch class of first endpoint
    logic     save_in1;     // latch class of second endpoint
    logic     init_search;  // set up bracket and first midpoint
    logic     step_adv;     // narrow bracket, next midpoint
    logic     finish;       // build the result and strobe it
  } cvlc_cmd_t;

  typedef struct packed {
    pt_class_e cls;         // class of the point in the scaler registers
    logic      in0;
    logic      in1;
  } cvlc_sts_t;

  // Magnitude of a two's complement coordinate; the most negative value maps exactly.
  function automatic logic [COORD_W-1:0] abs_coord(input coord_t a);
    logic [COORD_W-1:0] m;
    m = a[COORD_W-1] ? (~a + COORD_W'(1)) : a;
    return m;
  endfunction

  // Midpoint truncated toward zero.
  function automatic coord_t mid_point(input coord_t a, input coord_t b);
    logic [COORD_W:0] s;
    logic [COORD_W:0] t;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    t = s + {{COORD_W{1'b0}}, s[COORD_W]};
    return t[COORD_W:1];
  endfunction

  // Elaboration-time integer square root for the half-width table.
  function automatic int unsigned isqrt(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cvlc_datapath.sv
// Datapath of the line clipper: endpoint and bracket registers, point scaler,
// half-width table, midpoint unit and result registers. Uses cvlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvlc_datapath import cvlc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clip_scale_we_i,
  input  wire logic [SCALE_W-1:0] clip_scale_i,
  input  wire coord_t             start_x_i,
  input  wire coord_t             start_y_i,
  input  wire coord_t             end_x_i,
  input  wire coord_t             end_y_i,
  input  wire cvlc_cmd_t          cmd_i,
  output cvlc_sts_t               sts_o,
  output logic                    done_o,
  output logic                    visible_o,
  output coord_t                  clipped_start_x_o,
  output coord_t                  clipped_start_y_o,
  output coord_t                  clipped_end_x_o,
  output coord_t                  clipped_end_y_o
);

  logic [SCALE_W-1:0] scale_q;
  coord_t p0x_q, p0y_q, p1x_q, p1y_q;
  coord_t lox_q, loy_q, hix_q, hiy_q;
  coord_t gx_q, gy_q;
  logic [SC_W-1:0] sx_q, sy_q;
  logic in0_q, in1_q;
  logic done_q, vis_q;
  coord_t ox0_q, oy0_q, ox1_q, oy1_q;

  coord_t mx, my;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [RAD_W-1:0] hw;
  pt_class_e cls;

  // floor(sqrt(R^2 - y^2)) per scaled y
  logic [RAD_W-1:0] hw_rom [HW_DEPTH];
  for (genvar i = 0; i < HW_DEPTH; i++) begin : g_hw
    if (i <= CIRCLE_RADIUS) begin : g_in
      assign hw_rom[i] = RAD_W'(isqrt(CIRCLE_RADIUS * CIRCLE_RADIUS - i * i));
    end else begin : g_out
      assign hw_rom[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (clip_scale_we_i) begin
      scale_q <= clip_scale_i;
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MS_P0: begin
        mx = p0x_q;
        my = p0y_q;
      end
      MS_P1: begin
        mx = p1x_q;
        my = p1y_q;
      end
      default: begin
        mx = gx_q;
        my = gy_q;
      end
    endcase
  end

  assign prod_x = PROD_W'(abs_coord(mx)) * PROD_W'(scale_q);
  assign prod_y = PROD_W'(abs_coord(my)) * PROD_W'(scale_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      sx_q <= prod_x[PROD_W-1:FRAC_W];
      sy_q <= prod_y[PROD_W-1:FRAC_W];
    end
  end

  assign hw = hw_rom[sy_q[RAD_W-1:0]];

  always_comb begin
    if (sy_q > SC_W'(CIRCLE_RADIUS)) begin
      cls = PT_OUTSIDE;
    end else if (SC_W'(hw) > sx_q) begin
      cls = PT_INSIDE;
    end else if (SC_W'(hw) < sx_q) begin
      cls = PT_OUTSIDE;
    end else begin
      cls = PT_BOUNDARY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p0x_q <= start_x_i;
      p0y_q <= start_y_i;
      p1x_q <= end_x_i;
      p1y_q <= end_y_i;
    end
    if (cmd_i.save_in0) in0_q <= (cls != PT_OUTSIDE);
    if (cmd_i.save_in1) in1_q <= (cls != PT_OUTSIDE);
    if (cmd_i.init_search) begin
      lox_q <= in0_q ? p0x_q : p1x_q;
      loy_q <= in0_q ? p0y_q : p1y_q;
      hix_q <= in0_q ? p1x_q : p0x_q;
      hiy_q <= in0_q ? p1y_q : p0y_q;
      gx_q  <= mid_point(p0x_q, p1x_q);
      gy_q  <= mid_point(p0y_q, p1y_q);
    end else if (cmd_i.step_adv) begin
      if (cls == PT_OUTSIDE) begin
        hix_q <= gx_q;
        hiy_q <= gy_q;
        gx_q  <= mid_point(lox_q, gx_q);
        gy_q  <= mid_point(loy_q, gy_q);
      end else begin
        lox_q <= gx_q;
        loy_q <= gy_q;
        gx_q  <= mid_point(gx_q, hix_q);
        gy_q  <= mid_point(gy_q, hiy_q);
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      vis_q <= in0_q | in1_q;
      if (!in0_q && !in1_q) begin
        ox0_q <= '0;
        oy0_q <= '0;
        ox1_q <= '0;
        oy1_q <= '0;
      end else begin
        ox0_q <= (in0_q || !in1_q) ? p0x_q : gx_q;
        oy0_q <= (in0_q || !in1_q) ? p0y_q : gy_q;
        ox1_q <= (in1_q || !in0_q) ? p1x_q : gx_q;
        oy1_q <= (in1_q || !in0_q) ? p1y_q : gy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign sts_o.cls = cls;
  assign sts_o.in0 = in0_q;
  assign sts_o.in1 = in1_q;

  assign done_o            = done_q;
  assign visible_o         = vis_q;
  assign clipped_start_x_o = ox0_q;
  assign clipped_start_y_o = oy0_q;
  assign clipped_end_x_o   = ox1_q;
  assign clipped_end_y_o   = oy1_q;

endmodule

`default_nettype wire

>>> hdl/cvlc_ctrl.sv
// Controller of the line clipper: sequences the endpoint tests and the
// bisection steps and issues datapath commands. Uses cvlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvlc_ctrl import cvlc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire cvlc_sts_t sts_i,
  output logic           busy_o,
  output cvlc_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic last_step;

  assign last_step = (cnt_q == STEP_W'(SEARCH_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_MUL0;
      ST_MUL0:   state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_CHK1;
      ST_CHK1:   state_d = ST_DECIDE;
      ST_DECIDE: begin
        cnt_d   = '0;
        state_d = (sts_i.in0 == sts_i.in1) ? ST_IDLE : ST_MULG;
      end
      ST_MULG:   state_d = ST_CLSG;
      ST_CLSG: begin
        if (sts_i.cls == PT_BOUNDARY || last_step) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + STEP_W'(1);
          state_d = ST_MULG;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    cmd_o.mul_sel = MS_GUESS;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_MUL0: begin
        cmd_o.mul_sel = MS_P0;
        cmd_o.mul_en  = 1'b1;
      end
      ST_MUL1: begin
        cmd_o.mul_sel  = MS_P1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.save_in0 = 1'b1;
      end
      ST_CHK1:   cmd_o.save_in1 = 1'b1;
      ST_DECIDE: begin
        cmd_o.finish      = (sts_i.in0 == sts_i.in1);
        cmd_o.init_search = (sts_i.in0 != sts_i.in1);
      end
      ST_MULG:   cmd_o.mul_en = 1'b1;
      ST_CLSG: begin
        cmd_o.finish   = (sts_i.cls == PT_BOUNDARY) || last_step;
        cmd_o.step_adv = !((sts_i.cls == PT_BOUNDARY) || last_step);
      end
      default:   busy_o = 1'b1;
    endcase
  end

  a_no_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !cmd_o.finish)
    else $error("finish issued while idle");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= STEP_W'(SEARCH_COUNT))
    else $error("bisection step count overrun");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_adv_not_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.step_adv && cmd_o.finish))
    else $error("bisection advanced and finished together");

endmodule

`default_nettype wire

>>> hdl/circle_viewport_line_clipper.sv
// Top level of the circle viewport line clipper: ties the controller to the
// datapath. Depends on cvlc_pkg, cvlc_ctrl and cvlc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - Request: drive start_x_i/start_y_i/end_x_i/end_y_i and raise start_i; the
//   request is taken at a rising edge with start_i high and busy_o low.
// - Result: done_o pulses for one cycle with visible_o and the clipped
//   endpoints; the receiver must take it in that cycle, there is no stall.
//   Outputs hold their value until the next result.
// - Sequence: when both endpoints fall on the same side, the result follows the
//   endpoint tests directly, else it follows 1 to 11 bisection steps. Each
//   step is a scaler pass and then a classify/midpoint pass through the shared
//   point tester; busy_o is low in the same cycle as done_o, so the next
//   request may be taken while done_o is high.
// - Configuration: clip_scale_we_i writes clip_scale_i (unsigned 0.16 scale) at the
//   clock edge; write only while busy_o is low and no result is pending.
// - Reset: rst_ni low returns the controller to idle, clears done_o and sets
//   the scale to 495.
module circle_viewport_line_clipper import cvlc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clip_scale_we_i,
  input  wire logic [SCALE_W-1:0] clip_scale_i,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire coord_t             start_x_i,
  input  wire coord_t             start_y_i,
  input  wire coord_t             end_x_i,
  input  wire coord_t             end_y_i,
  output logic                    done_o,
  output logic                    visible_o,
  output coord_t                  clipped_start_x_o,
  output coord_t                  clipped_start_y_o,
  output coord_t                  clipped_end_x_o,
  output coord_t                  clipped_end_y_o
);

  cvlc_cmd_t cmd;
  cvlc_sts_t sts;

  cvlc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  cvlc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clip_scale_we_i  (clip_scale_we_i),
    .clip_scale_i     (clip_scale_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .done_o           (done_o),
    .visible_o        (visible_o),
    .clipped_start_x_o(clipped_start_x_o),
    .clipped_start_y_o(clipped_start_y_o),
    .clipped_end_x_o  (clipped_end_x_o),
    .clipped_end_y_o  (clipped_end_y_o)
  );

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for circle_viewport_line_clipper: predicts every clip
// result in its own model and checks it field by field at the result strobe.
// Depends on cvlc_pkg and the RTL of the block only.

module tb_top;
  import cvlc_pkg::*;

  localparam longint COORD_MAX    = 8388607;
  localparam longint COORD_MIN    = -8388608;
  localparam int     DRAIN_CYCLES = 40;    // covers the longest bisection
  localparam int     STALL_LIMIT  = 4000;  // cycles without any request or result

  // One segment request and one clip result, as the ports carry them.
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } segment_t;

  typedef struct packed {
    logic   visible;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } clip_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               clip_scale_we_i = 1'b0;
  logic [SCALE_W-1:0] clip_scale_i = '0;
  logic               start_i = 1'b0;
  coord_t             start_x_i = '0;
  coord_t             start_y_i = '0;
  coord_t             end_x_i = '0;
  coord_t             end_y_i = '0;
  logic               busy_o;
  logic               done_o;
  logic               visible_o;
  coord_t             clipped_start_x_o;
  coord_t             clipped_start_y_o;
  coord_t             clipped_end_x_o;
  coord_t             clipped_end_y_o;

  circle_viewport_line_clipper dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .clip_scale_we_i   (clip_scale_we_i),
    .clip_scale_i      (clip_scale_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .done_o            (done_o),
    .visible_o         (visible_o),
    .clipped_start_x_o (clipped_start_x_o),
    .clipped_start_y_o (clipped_start_y_o),
    .clipped_end_x_o   (clipped_end_x_o),
    .clipped_end_y_o   (clipped_end_y_o)
  );

  always #2 clk_i = ~clk_i;

  // Bench state: requests still to send, predictions still to check.
  segment_t           pending_segments[$];
  clip_t              expected_clips[$];
  logic [SCALE_W-1:0] model_scale = SCALE_RESET;  // scale as the block holds it
  int unsigned        idle_pct = 0;               // sender stall chance, percent
  int                 mismatch_count = 0;
  int                 quiet_cycles = 0;
  bit                 accept_seen = 1'b0;
  segment_t           seg_next;
  clip_t              clip_want;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Point test: scale |x| and |y| by s (unsigned 0.16), then compare x against the
  // half-width of the circle at the scaled y. Boundary is reported apart.
  function automatic pt_class_e classify_point(coord_t px, coord_t py,
                                               logic [SCALE_W-1:0] s);
    longint unsigned mx, my, sx, sy, room, hw;
    mx = (px < 0) ? -longint'(px) : longint'(px);
    my = (py < 0) ? -longint'(py) : longint'(py);
    sy = (my * s) >> FRAC_W;
    if (sy > CIRCLE_RADIUS) return PT_OUTSIDE;
    sx = (mx * s) >> FRAC_W;
    room = CIRCLE_RADIUS * CIRCLE_RADIUS - sy * sy;
    hw = 0;
    while ((hw + 1) * (hw + 1) <= room) hw++;
    if (hw > sx) return PT_INSIDE;
    if (hw < sx) return PT_OUTSIDE;
    return PT_BOUNDARY;
  endfunction

  // Whole segment: pass, reject, or bisect toward the circle edge.
  function automatic clip_t clip_segment(segment_t sg, logic [SCALE_W-1:0] s);
    longint    lo_x, lo_y, hi_x, hi_y, gx, gy;
    bit        in_a, in_b, hit;
    pt_class_e c;
    clip_t     r;
    in_a = classify_point(sg.x0, sg.y0, s) != PT_OUTSIDE;
    in_b = classify_point(sg.x1, sg.y1, s) != PT_OUTSIDE;
    r = '0;
    if (!in_a && !in_b) return r;  // rejected: coordinates read as zero
    r.visible = 1'b1;
    r.x0 = sg.x0;
    r.y0 = sg.y0;
    r.x1 = sg.x1;
    r.y1 = sg.y1;
    if (in_a && in_b) return r;
    if (in_a) begin
      lo_x = sg.x0; lo_y = sg.y0; hi_x = sg.x1; hi_y = sg.y1;
    end else begin
      lo_x = sg.x1; lo_y = sg.y1; hi_x = sg.x0; hi_y = sg.y0;
    end
    gx = 0;
    gy = 0;
    hit = 1'b0;
    for (int k = 0; k <= int'(SEARCH_COUNT) && !hit; k++) begin
      // longint division truncates toward zero, same as the block's midpoint
      gx = (lo_x + hi_x) / 2;
      gy = (lo_y + hi_y) / 2;
      c = classify_point(coord_t'(gx), coord_t'(gy), s);
      case (c)
        PT_OUTSIDE: begin
          hi_x = gx; hi_y = gy;
        end
        PT_INSIDE: begin
          lo_x = gx; lo_y = gy;
        end
        default: hit = 1'b1;  // landed on the edge, stop early
      endcase
    end
    if (in_a) begin
      r.x1 = coord_t'(gx); r.y1 = coord_t'(gy);
    end else begin
      r.x0 = coord_t'(gx); r.y0 = coord_t'(gy);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: holds a request until taken, then pops the next one or idles.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!start_i || accept_seen) begin
      if (pending_segments.size() != 0 && $urandom_range(99) >= idle_pct) begin
        seg_next = pending_segments.pop_front();
        start_i   <= 1'b1;
        start_x_i <= seg_next.x0;
        start_y_i <= seg_next.y0;
        end_x_i   <= seg_next.x1;
        end_y_i   <= seg_next.y1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results, predicts taken requests, runs the watchdog.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    // result first: a request taken at this same edge belongs behind it
    if (done_o) begin
      if (expected_clips.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatch_count++;
      end else begin
        clip_want = expected_clips.pop_front();
        check_field("visible", clip_want.visible, visible_o);
        check_field("clipped_start_x", clip_want.x0, clipped_start_x_o);
        check_field("clipped_start_y", clip_want.y0, clipped_start_y_o);
        check_field("clipped_end_x", clip_want.x1, clipped_end_x_o);
        check_field("clipped_end_y", clip_want.y1, clipped_end_y_o);
      end
    end
    accept_seen = rst_ni && start_i && !busy_o;
    if (accept_seen)
      expected_clips.push_back(
        clip_segment('{start_x_i, start_y_i, end_x_i, end_y_i}, model_scale));
    if (accept_seen || done_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic coord_t to_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return coord_t'(v);
  endfunction

  task automatic push_segment(longint ax, longint ay, longint bx, longint by);
    segment_t sg;
    sg.x0 = to_coord(ax);
    sg.y0 = to_coord(ay);
    sg.x1 = to_coord(bx);
    sg.y1 = to_coord(by);
    pending_segments.push_back(sg);
  endtask

  // uniform in [-span, span]
  function automatic longint spread(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  // magnitude between one and three circle radii, either sign
  function automatic longint beyond_edge(longint rmap);
    longint m;
    m = rmap + longint'($urandom_range(32'(2 * rmap)));
    return $urandom_range(1) ? m : -m;
  endfunction

  function automatic longint full_range();
    return longint'($urandom_range(16777215)) + COORD_MIN;
  endfunction

  function automatic longint pick_extreme(longint rmap);
    case ($urandom_range(5))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return $urandom_range(1) ? rmap : -rmap;
    endcase
  endfunction

  // Most traffic crosses the circle edge so the bisection runs; the rest is
  // short segments near the circle, full-range noise and corner values.
  task automatic add_random_segments(int count, logic [SCALE_W-1:0] s);
    longint rmap, ix, iy, ox, oy;
    // circle radius in map units at this scale
    rmap = (s == 0) ? COORD_MAX : (longint'(CIRCLE_RADIUS) << FRAC_W) / s + 1;
    if (rmap > COORD_MAX) rmap = COORD_MAX;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          ix = spread(rmap * 7 / 10);
          iy = spread(rmap * 7 / 10);
          ox = beyond_edge(rmap);
          oy = spread(rmap);
          if ($urandom_range(1)) begin
            // outside along y instead of x
            longint t;
            t = ox; ox = oy; oy = t;
          end
          if ($urandom_range(1)) push_segment(ix, iy, ox, oy);
          else push_segment(ox, oy, ix, iy);
        end
        6: push_segment(spread(rmap * 3 / 2), spread(rmap * 3 / 2),
                        spread(rmap * 3 / 2), spread(rmap * 3 / 2));
        7: push_segment(full_range(), full_range(), full_range(), full_range());
        8: push_segment(full_range(), full_range(), spread(rmap / 2), spread(rmap / 2));
        default: push_segment(pick_extreme(rmap), pick_extreme(rmap),
                              pick_extreme(rmap), pick_extreme(rmap));
      endcase
    end
  endtask

  // Idle means: nothing queued, nothing in flight, nothing left to check.
  task automatic wait_quiet();
    @(posedge clk_i);
    while (pending_segments.size() != 0 || expected_clips.size() != 0 || start_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [SCALE_W-1:0] s, int unsigned stall_pct, int count);
    wait_quiet();
    @(negedge clk_i);
    clip_scale_we_i <= 1'b1;
    clip_scale_i    <= s;
    model_scale = s;
    @(negedge clk_i);
    clip_scale_we_i <= 1'b0;
    idle_pct = stall_pct;
    add_random_segments(count, s);
  endtask

  initial begin
    // reset held low, then released away from the clock edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed set at the reset scale of 495: one circle radius is about
    // 13107 map units, and 13108 scales to exactly 99 (on the edge).
    idle_pct = 0;
    push_segment(0, 0, 0, 0);                              // zero length, centre
    push_segment(1, -1, -100, 200);                        // both inside
    push_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX); // both out, crosses
    push_segment(0, 0, COORD_MAX, 0);                      // inside to outside
    push_segment(COORD_MIN, 0, 0, 0);                      // most negative, outside first
    push_segment(0, COORD_MIN, 5, 5);
    push_segment(13108, 0, 0, 0);                          // edge endpoint counts inside
    push_segment(0, 13108, 40000, 40000);                  // edge at the top of the circle
    push_segment(13108, 0, -13108, 0);                     // both on the edge
    push_segment(0, 0, 26216, 0);                          // first midpoint hits the edge
    push_segment(-1, -1, COORD_MIN, COORD_MAX);
    push_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX); // one outside point
    push_segment(9000, 9000, 20000, -3);
    push_segment(-13200, 0, -13000, 0);                    // short hop over the edge
    push_segment(0, 100000, 0, -100000);                   // both out, through centre
    push_segment(3, -7, -20000, -15000);
    push_segment(-1, 0, 0, -1);
    push_segment(-9269, 9269, -9268, 9268);                // near the diagonal edge

    // Random phases: scale extremes and random scales, three stall regimes.
    run_phase(SCALE_W'(8191), 23, 170);
    run_phase(SCALE_RESET, 23, 170);
    run_phase(SCALE_W'(1), 81, 150);
    run_phase(SCALE_W'(0), 81, 60);   // everything scales to zero: all pass
    run_phase(SCALE_W'($urandom_range(8191)), 0, 220);
    run_phase(SCALE_W'($urandom_range(1, 2000)), 0, 220);

    wait_quiet();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
